>>> src/lrg_pkg.sv
// Shared types and constants for the localization radius grouping core.
// Used by lrg_cell, lrg_match and localization_radius_grouping_core.
package lrg_pkg;

    localparam int MAX_GROUPS = 1024;
    localparam int IDX_W      = $clog2(MAX_GROUPS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int POS_W      = 24;
    localparam int FRM_W      = 20;
    localparam int SQ_W       = 2 * POS_W;
    localparam int SPAN_W     = 16;
    localparam int RAD_W      = 16;
    localparam int R2_W       = 2 * RAD_W;
    localparam int GIDX_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DRAIN_CYC  = 3;
    localparam int DRAIN_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROI_LEFT,
        CFG_ROI_TOP,
        CFG_ROI_SPAN_X,
        CFG_ROI_SPAN_Y,
        CFG_RADIUS,
        CFG_DARK_TIME,
        CFG_DARK_MODE
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [FRM_W-1:0] frame;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic frame_only;
    } cell_ctrl_t;

endpackage

>>> src/lrg_cell.sv
// One ring cell holding a stored group start and its last member frame.
// Depends on lrg_pkg.
module lrg_cell (
    input  logic                aclk,
    input  lrg_pkg::cell_ctrl_t ctrl,
    input  logic                wr_en,
    input  lrg_pkg::entry_t     wr_data,
    input  lrg_pkg::entry_t     shift_in,
    output lrg_pkg::entry_t     data_out
);

    lrg_pkg::entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            entry_reg <= shift_in;
        end else if (wr_en) begin
            if (ctrl.frame_only) begin
                entry_reg.frame <= wr_data.frame;
            end else begin
                entry_reg <= wr_data;
            end
        end
    end

    assign data_out = entry_reg;

endmodule

>>> src/lrg_match.sv
// Three-stage distance and frame-gap test on the entry at the ring head.
// Depends on lrg_pkg.
module lrg_match (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          issue_valid,
    input  logic [lrg_pkg::IDX_W-1:0]     issue_idx,
    input  lrg_pkg::entry_t               entry,
    input  logic [lrg_pkg::POS_W-1:0]     pos_x,
    input  logic [lrg_pkg::POS_W-1:0]     pos_y,
    input  logic [lrg_pkg::FRM_W-1:0]     frame_no,
    input  logic [lrg_pkg::R2_W-1:0]      r2,
    input  logic [lrg_pkg::FRM_W-1:0]     dark_time,
    input  logic                          dark_mode,
    output logic                          hit_valid,
    output logic [lrg_pkg::IDX_W-1:0]     hit_idx
);

    logic                        v1_reg, v2_reg, hit_reg;
    logic [lrg_pkg::IDX_W-1:0]   idx1_reg, idx2_reg, idx3_reg;
    logic [lrg_pkg::POS_W-1:0]   dx_reg, dy_reg;
    logic [lrg_pkg::FRM_W-1:0]   lf_reg;
    logic [lrg_pkg::SQ_W-1:0]    sqx_reg, sqy_reg;
    logic                        gap_ok_reg;
    logic [lrg_pkg::SQ_W:0]      dist2;

    assign dist2 = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end else begin
            v1_reg  <= issue_valid;
            v2_reg  <= v1_reg;
            hit_reg <= v2_reg && (dist2 <= (lrg_pkg::SQ_W+1)'(r2))
                       && (!dark_mode || gap_ok_reg);
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg   <= issue_idx;
        dx_reg     <= (pos_x >= entry.x) ? pos_x - entry.x : entry.x - pos_x;
        dy_reg     <= (pos_y >= entry.y) ? pos_y - entry.y : entry.y - pos_y;
        lf_reg     <= entry.frame;
        idx2_reg   <= idx1_reg;
        sqx_reg    <= lrg_pkg::SQ_W'(dx_reg) * lrg_pkg::SQ_W'(dx_reg);
        sqy_reg    <= lrg_pkg::SQ_W'(dy_reg) * lrg_pkg::SQ_W'(dy_reg);
        gap_ok_reg <= (frame_no < lf_reg) || ((frame_no - lf_reg) <= dark_time);
        idx3_reg   <= idx2_reg;
    end

    assign hit_valid = hit_reg;
    assign hit_idx   = idx3_reg;

endmodule

>>> src/localization_radius_grouping_core.sv
// Localization radius grouping core: ROI filter plus greedy radius grouping.
// Top level; depends on lrg_pkg, lrg_cell and lrg_match.
//
// Usage:
//   Input channel s_*: one localization per transaction (pos_x, pos_y,
//   frame_no, restart). Result channel m_*: one result per transaction.
//   Configuration channel cfg_*: cfg_index selects the register, cfg_data
//   carries the value; write only while the core is idle.
//   Group starts live in a ring of MAX_GROUPS cells that, while scanning,
//   rotates one cell per cycle past a single pipelined distance unit at
//   the ring head. A point inside the ROI goes through one full ring
//   rotation, the three test stages and, unless the store is full, a write
//   before its result; a point outside the ROI skips the scan. One point
//   is handled at a time. The result waits in an output register; while the
//   receiver stalls, the core still takes the next point but holds its result.
//   Reset clears the group count, the handshakes and restores the register
//   defaults; stored group starts need no clearing.
module localization_radius_grouping_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lrg_pkg::POS_W-1:0]         s_pos_x,
    input  logic [lrg_pkg::POS_W-1:0]         s_pos_y,
    input  logic [lrg_pkg::FRM_W-1:0]         s_frame_no,
    input  logic                              s_restart,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_inside_roi,
    output logic [lrg_pkg::GIDX_W-1:0]        m_group_index,
    output logic                              m_new_group,
    output logic                              m_overflow,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lrg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lrg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int N = lrg_pkg::MAX_GROUPS;

    lrg_pkg::state_t                  state_reg, state_next;
    logic [lrg_pkg::POS_W-1:0]        roi_left_reg, roi_top_reg;
    logic [lrg_pkg::SPAN_W-1:0]       span_x_reg, span_y_reg;
    logic [lrg_pkg::RAD_W-1:0]        radius_reg;
    logic [lrg_pkg::R2_W-1:0]         r2_reg;
    logic [lrg_pkg::FRM_W-1:0]        dark_time_reg;
    logic                             dark_mode_reg;

    logic [lrg_pkg::POS_W-1:0]        x_reg, y_reg;
    logic [lrg_pkg::FRM_W-1:0]        frm_reg;
    logic                             roi_reg, roi_next;
    logic [lrg_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [lrg_pkg::CNT_W-1:0]        scan_reg, scan_next;
    logic [lrg_pkg::DRAIN_W-1:0]      drain_reg, drain_next;
    logic                             found_reg, found_next;
    logic [lrg_pkg::IDX_W-1:0]        match_reg, match_next;

    logic                             m_valid_reg, m_valid_next;
    logic                             out_inside_reg, out_inside_next;
    logic [lrg_pkg::GIDX_W-1:0]       out_idx_reg, out_idx_next;
    logic                             out_new_reg, out_new_next;
    logic                             out_ovf_reg, out_ovf_next;

    logic                             s_fire, roi_ok;
    logic [lrg_pkg::POS_W:0]          x_hi, y_hi;
    logic                             wr_fire;
    logic [lrg_pkg::IDX_W-1:0]        wr_idx;
    lrg_pkg::cell_ctrl_t              ctrl;
    lrg_pkg::entry_t                  wr_data;
    lrg_pkg::entry_t                  ring [N];
    logic                             hit_valid;
    logic [lrg_pkg::IDX_W-1:0]        hit_idx;
    logic                             issue_valid;

    assign s_ready   = (state_reg == lrg_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign x_hi   = {1'b0, roi_left_reg} + {1'b0, span_x_reg, 8'b0};
    assign y_hi   = {1'b0, roi_top_reg} + {1'b0, span_y_reg, 8'b0};
    assign roi_ok = (s_pos_x >= roi_left_reg) && ({1'b0, s_pos_x} <= x_hi)
                 && (s_pos_y >= roi_top_reg) && ({1'b0, s_pos_y} <= y_hi);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roi_left_reg  <= '0;
            roi_top_reg   <= '0;
            span_x_reg    <= 16'hFFFF;
            span_y_reg    <= 16'hFFFF;
            radius_reg    <= 16'd128;
            dark_time_reg <= 20'd100;
            dark_mode_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (lrg_pkg::cfg_idx_t'(cfg_index))
                lrg_pkg::CFG_ROI_LEFT:   roi_left_reg  <= cfg_data[lrg_pkg::POS_W-1:0];
                lrg_pkg::CFG_ROI_TOP:    roi_top_reg   <= cfg_data[lrg_pkg::POS_W-1:0];
                lrg_pkg::CFG_ROI_SPAN_X: span_x_reg    <= cfg_data[lrg_pkg::SPAN_W-1:0];
                lrg_pkg::CFG_ROI_SPAN_Y: span_y_reg    <= cfg_data[lrg_pkg::SPAN_W-1:0];
                lrg_pkg::CFG_RADIUS:     radius_reg    <= cfg_data[lrg_pkg::RAD_W-1:0];
                lrg_pkg::CFG_DARK_TIME:  dark_time_reg <= cfg_data[lrg_pkg::FRM_W-1:0];
                lrg_pkg::CFG_DARK_MODE:  dark_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        r2_reg <= lrg_pkg::R2_W'(radius_reg) * lrg_pkg::R2_W'(radius_reg);
        if (s_fire) begin
            x_reg   <= s_pos_x;
            y_reg   <= s_pos_y;
            frm_reg <= s_frame_no;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lrg_pkg::ST_IDLE;
            count_reg   <= '0;
            scan_reg    <= '0;
            drain_reg   <= '0;
            found_reg   <= 1'b0;
            roi_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            scan_reg    <= scan_next;
            drain_reg   <= drain_next;
            found_reg   <= found_next;
            roi_reg     <= roi_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        match_reg      <= match_next;
        out_inside_reg <= out_inside_next;
        out_idx_reg    <= out_idx_next;
        out_new_reg    <= out_new_next;
        out_ovf_reg    <= out_ovf_next;
    end

    assign issue_valid = (state_reg == lrg_pkg::ST_SCAN) && (scan_reg < count_reg);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        drain_next      = drain_reg;
        found_next      = found_reg;
        match_next      = match_reg;
        roi_next        = roi_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_inside_next = out_inside_reg;
        out_idx_next    = out_idx_reg;
        out_new_next    = out_new_reg;
        out_ovf_next    = out_ovf_reg;
        ctrl.shift      = 1'b0;
        ctrl.frame_only = 1'b0;
        wr_fire         = 1'b0;
        wr_idx          = match_reg;
        wr_data.x       = x_reg;
        wr_data.y       = y_reg;
        wr_data.frame   = frm_reg;

        if (hit_valid && !found_reg) begin
            found_next = 1'b1;
            match_next = hit_idx;
        end

        case (state_reg)
            lrg_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_restart) begin
                        count_next = '0;
                    end
                    roi_next   = roi_ok;
                    scan_next  = '0;
                    found_next = 1'b0;
                    state_next = roi_ok ? lrg_pkg::ST_SCAN : lrg_pkg::ST_FINISH;
                end
            end
            lrg_pkg::ST_SCAN: begin
                ctrl.shift = 1'b1;
                scan_next  = scan_reg + 1'b1;
                if (scan_reg == lrg_pkg::CNT_W'(N - 1)) begin
                    drain_next = '0;
                    state_next = lrg_pkg::ST_DRAIN;
                end
            end
            lrg_pkg::ST_DRAIN: begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == lrg_pkg::DRAIN_W'(lrg_pkg::DRAIN_CYC - 1)) begin
                    state_next = lrg_pkg::ST_FINISH;
                end
            end
            lrg_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    out_inside_next = 1'b0;
                    out_idx_next    = '0;
                    out_new_next    = 1'b0;
                    out_ovf_next    = 1'b0;
                    if (roi_reg) begin
                        if (found_reg) begin
                            wr_fire         = 1'b1;
                            ctrl.frame_only = 1'b1;
                            wr_idx          = match_reg;
                            out_inside_next = 1'b1;
                            out_idx_next    = lrg_pkg::GIDX_W'(match_reg);
                        end else if (count_reg == lrg_pkg::CNT_W'(N)) begin
                            out_ovf_next = 1'b1;
                        end else begin
                            wr_fire         = 1'b1;
                            wr_idx          = count_reg[lrg_pkg::IDX_W-1:0];
                            count_next      = count_reg + 1'b1;
                            out_inside_next = 1'b1;
                            out_idx_next    = lrg_pkg::GIDX_W'(count_reg[lrg_pkg::IDX_W-1:0]);
                            out_new_next    = 1'b1;
                        end
                    end
                    state_next = lrg_pkg::ST_IDLE;
                end
            end
            default: state_next = lrg_pkg::ST_IDLE;
        endcase
    end

    for (genvar i = 0; i < N; i++) begin : g_ring
        lrg_cell u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .wr_en    (wr_fire && (wr_idx == lrg_pkg::IDX_W'(i))),
            .wr_data  (wr_data),
            .shift_in (ring[(i + 1) % N]),
            .data_out (ring[i])
        );
    end

    lrg_match u_match (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .issue_valid (issue_valid),
        .issue_idx   (scan_reg[lrg_pkg::IDX_W-1:0]),
        .entry       (ring[0]),
        .pos_x       (x_reg),
        .pos_y       (y_reg),
        .frame_no    (frm_reg),
        .r2          (r2_reg),
        .dark_time   (dark_time_reg),
        .dark_mode   (dark_mode_reg),
        .hit_valid   (hit_valid),
        .hit_idx     (hit_idx)
    );

    assign m_valid       = m_valid_reg;
    assign m_inside_roi  = out_inside_reg;
    assign m_group_index = out_idx_reg;
    assign m_new_group   = out_new_reg;
    assign m_overflow    = out_ovf_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= lrg_pkg::CNT_W'(N))
        else $error("group count beyond store size");

    a_new_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_new_group |-> m_inside_roi && !m_overflow)
        else $error("new group result not flagged inside");

    a_hit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_valid |-> ({1'b0, hit_idx} < count_reg))
        else $error("match on an unused group entry");

    a_scan_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lrg_pkg::ST_DRAIN |-> scan_reg == lrg_pkg::CNT_W'(N))
        else $error("ring not realigned after scan");

endmodule
